// File: src/fls_pkg.sv
// Shared types and constants for the free-list slot allocator.
`default_nettype none

package fls_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned LINK_W   = 8;
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned ACTION_W = 2;

  // Action codes carried in the input item.
  localparam logic [ACTION_W-1:0] ACT_INIT  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd2;

  // Reset value of the slot count register.
  localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 9'd256;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_EMPTY      = 2'd1,
    STATUS_BAD_CONFIG = 2'd2,
    STATUS_FULL       = 2'd3
  } status_e;

  // Control sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_INIT  = 3'b010,
    ST_ALLOC = 3'b100
  } state_e;

  // One result item.
  typedef struct packed {
    status_e           status;
    logic [LINK_W-1:0] granted_slot;
    logic [CNT_W-1:0]  free_count;
  } res_t;

endpackage

`default_nettype wire

// File: src/fls_link_ram.sv
// Link memory: one write port, one read port with registered read data.
`default_nettype none

module fls_link_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/free_list_slot_allocator_core.sv
// Top level of the free-list slot allocator: sequencer, pool registers and result queue.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser = {has_slot, action}, tdata = slot_index
//  m_axis    out        tuser = status, tdata = {free_count, granted_slot}
//  cfg       in         cfg_wdata_i = slot_count, written when cfg_we_i is high
//
// A successful allocate reads the head's link from the link memory, then updates
// the head. An allocate from an empty pool, a free, a null free, a rejected init
// and the unused action are answered from the idle state without a memory read.
// An init makes one link memory write per linked slot, one write per cycle. After reset the
// pool is empty and the link memory holds no valid links until an init; there
// is no clearing pass. While the output is stalled one finished result can wait
// in a holding register, and input items are refused while it is occupied.
`default_nettype none

module free_list_slot_allocator_core #(
  parameter int unsigned SLOTS = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input items.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] slot_index
  input  wire logic [2:0]  s_axis_tuser,  // [1:0] action, [2] has_slot
  // Result items.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // [7:0] granted_slot, [16:8] free_count
  output logic [1:0]       m_axis_tuser,  // [1:0] status
  // Configuration.
  input  wire logic        cfg_we_i,
  input  wire logic [fls_pkg::CNT_W-1:0] cfg_wdata_i
);

  import fls_pkg::*;

  // Slot indices are 8 bits wide, so the pool never exceeds 256 slots.
  localparam int unsigned DEPTH = (SLOTS < 256) ? SLOTS : 256;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [CNT_W-1:0]  slot_count_q;
  logic [LINK_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  free_q, free_d;
  logic [CNT_W-1:0]  pool_q, pool_d;
  logic [CNT_W-1:0]  ctr_q, ctr_d;
  state_e            state_q, state_d;
  res_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;
  res_t              pend_q, pend_d;
  logic              pend_valid_q, pend_valid_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [LINK_W-1:0] ram_wdata, ram_rdata;

  logic              in_acc;
  logic              out_free;
  logic [CNT_W-1:0]  n_cap;
  logic [1:0]        in_action;
  logic              in_has_slot;
  logic [LINK_W-1:0] in_slot;
  res_t              res;
  logic              res_vld;

  assign in_action   = s_axis_tuser[1:0];
  assign in_has_slot = s_axis_tuser[2];
  assign in_slot     = s_axis_tdata;

  assign s_axis_tready = (state_q == ST_IDLE) && !pend_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Slot count limited to the memory depth.
  assign n_cap = (slot_count_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : slot_count_q;

  fls_link_ram #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .DW   (LINK_W)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Sequencer and pool bookkeeping.
  always_comb begin
    head_d    = head_q;
    free_d    = free_q;
    pool_d    = pool_q;
    ctr_d     = ctr_q;
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = head_q[AW-1:0];
    res_vld   = 1'b0;
    res       = '0;
    res.status = STATUS_OK;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_action)
            ACT_INIT: begin
              if (n_cap == '0) begin
                res.status = STATUS_BAD_CONFIG;
                res_vld    = 1'b1;
              end else begin
                // Slot 0 ends the list; the walk links the rest.
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '0;
                head_d    = LINK_W'(n_cap - CNT_W'(1));
                free_d    = n_cap;
                pool_d    = n_cap;
                if (n_cap == CNT_W'(1)) begin
                  res_vld = 1'b1;
                end else begin
                  ctr_d   = CNT_W'(1);
                  state_d = ST_INIT;
                end
              end
            end
            ACT_ALLOC: begin
              if (free_q == '0) begin
                res.status = STATUS_EMPTY;
                res_vld    = 1'b1;
              end else begin
                ram_re  = 1'b1;
                state_d = ST_ALLOC;
              end
            end
            ACT_FREE: begin
              if (in_has_slot) begin
                if (free_q >= pool_q) begin
                  res.status = STATUS_FULL;
                end else if ({1'b0, in_slot} >= pool_q) begin
                  res.status = STATUS_BAD_CONFIG;
                end else begin
                  ram_we    = 1'b1;
                  ram_waddr = in_slot[AW-1:0];
                  ram_wdata = head_q;
                  head_d    = in_slot;
                  free_d    = free_q + CNT_W'(1);
                end
              end
              res_vld = 1'b1;
            end
            default: begin
              res_vld = 1'b1;
            end
          endcase
        end
      end
      ST_INIT: begin
        // Each slot links to the one below it.
        ram_we    = 1'b1;
        ram_waddr = ctr_q[AW-1:0];
        ram_wdata = LINK_W'(ctr_q - CNT_W'(1));
        ctr_d     = ctr_q + CNT_W'(1);
        if (ctr_q == pool_q - CNT_W'(1)) begin
          res_vld = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_ALLOC: begin
        // Link of the old head is back from memory.
        res.granted_slot = head_q;
        head_d           = ram_rdata;
        free_d           = free_q - CNT_W'(1);
        res_vld          = 1'b1;
        state_d          = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res.free_count = free_d;
  end

  // Output register with one holding slot behind it.
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    if (res_vld) begin
      if (out_free) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        pend_d       = res;
        pend_valid_d = 1'b1;
      end
    end else if (pend_valid_q && out_free) begin
      out_d        = pend_q;
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SLOT_COUNT_RST;
      head_q       <= '0;
      free_q       <= '0;
      pool_q       <= '0;
      ctr_q        <= '0;
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        slot_count_q <= cfg_wdata_i;
      end
      head_q       <= head_d;
      free_q       <= free_d;
      pool_q       <= pool_d;
      ctr_q        <= ctr_d;
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {7'b0, out_q.free_count, out_q.granted_slot};

  // The free count never exceeds the pool size.
  a_free_le_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= pool_q)
    else $error("free count above pool size");

  // A held result always has a result in front of it.
  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("held result with empty output register");

  // An allocate only reaches the memory read when a slot is free.
  a_alloc_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ALLOC) |-> (free_q != '0))
    else $error("allocate from an empty pool");

  // The init walk stays inside the pool.
  a_init_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |-> (ctr_q < pool_q && ctr_q != '0))
    else $error("init walk out of range");

endmodule

`default_nettype wire

// File: verif/free_list_slot_allocator_core_tb.sv
// Self-checking testbench for the free-list slot allocator core.
`timescale 1ns / 1ps

module free_list_slot_allocator_core_tb;

  import fls_pkg::*;

  localparam int unsigned SLOTS = 256;
  localparam int unsigned LONG_HOLD_CYCLES = 64;
  // Action code that the block ignores.
  localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // [7:0] slot_index
  logic [2:0] s_axis_tuser = '0;   // [1:0] action, [2] has_slot
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // [7:0] granted_slot, [16:8] free_count
  logic [1:0] m_axis_tuser;        // [1:0] status
  logic cfg_we_i = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;

  free_list_slot_allocator_core #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Predicted pool state: links, head, free count, linked size and the register.
  logic [LINK_W-1:0] link_mem [SLOTS];
  logic [LINK_W-1:0] head_q = '0;
  logic [CNT_W-1:0] free_q = '0;
  logic [CNT_W-1:0] pool_q = '0;
  logic [CNT_W-1:0] slot_count_q = SLOT_COUNT_RST;

  res_t expected_pool_results[$];
  // Slots handed out and not yet returned, used to build well-formed frees.
  logic [LINK_W-1:0] granted_slots_out[$];

  bit src_gaps_on = 1'b1;
  bit sink_stalls_on = 1'b1;
  bit long_hold_req = 1'b0;
  bit pool_draining = 1'b0;
  int unsigned err_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned settings_used = 0;
  logic [3:0] status_seen = '0;

  // Apply one item to the predicted pool and return the result it should give.
  function automatic res_t pool_predict(input logic [ACTION_W-1:0] action,
                                        input logic has_slot,
                                        input logic [LINK_W-1:0] slot);
    res_t r;
    logic [CNT_W-1:0] n;
    int i;
    r.status = STATUS_OK;
    r.granted_slot = '0;
    case (action)
      ACT_INIT: begin
        n = (slot_count_q > SLOTS) ? CNT_W'(SLOTS) : slot_count_q;
        if (n == 0) begin
          r.status = STATUS_BAD_CONFIG;
        end else begin
          // Slot n-1 ends up at the head, each slot links to the one below.
          link_mem[0] = '0;
          for (i = 1; i < n; i++) link_mem[i] = LINK_W'(i - 1);
          head_q = LINK_W'(n - 1);
          free_q = n;
          pool_q = n;
        end
      end
      ACT_ALLOC: begin
        if (free_q == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.granted_slot = head_q;
          head_q = link_mem[head_q];
          free_q = free_q - 1'b1;
        end
      end
      ACT_FREE: begin
        if (has_slot) begin
          if (free_q >= pool_q) begin
            r.status = STATUS_FULL;
          end else if ({1'b0, slot} >= pool_q) begin
            r.status = STATUS_BAD_CONFIG;
          end else begin
            link_mem[slot] = head_q;
            head_q = slot;
            free_q = free_q + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    r.free_count = free_q;
    return r;
  endfunction

  // Offer one item, wait until it is taken, then record what it should produce.
  task automatic issue_pool_request(input logic [ACTION_W-1:0] action,
                                    input logic has_slot,
                                    input logic [LINK_W-1:0] slot);
    res_t r;
    if (!s_axis_tvalid) s_axis_tvalid <= 1'b1;
    s_axis_tdata <= slot;
    s_axis_tuser <= {has_slot, action};
    do @(posedge clk_i); while (!s_axis_tready);
    r = pool_predict(action, has_slot, slot);
    expected_pool_results.push_back(r);
    items_sent++;
    if (action == ACT_ALLOC && r.status == STATUS_OK) granted_slots_out.push_back(r.granted_slot);
    if (action == ACT_INIT && r.status == STATUS_OK) granted_slots_out.delete();
    if (src_gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_pool_results.size() != 0);
  endtask

  // The register is only written with the block idle.
  task automatic write_slot_count(input logic [CNT_W-1:0] value);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    slot_count_q = value;
    settings_used++;
  endtask

  // Mostly well-formed alloc/free traffic that walks the pool down and back up,
  // with some re-inits, null frees, stray indexes and ignored actions mixed in.
  task automatic send_random_item();
    int unsigned roll;
    int unsigned pick;
    logic [ACTION_W-1:0] act;
    logic has;
    logic [LINK_W-1:0] slot;
    roll = $urandom_range(0, 99);
    has = 1'($urandom_range(0, 1));
    slot = LINK_W'($urandom);
    if (free_q == 0) pool_draining = 1'b0;
    else if (free_q == pool_q) pool_draining = 1'b1;
    if ($urandom_range(0, 49) == 0) pool_draining = !pool_draining;
    if (roll < 3) begin
      act = ACT_INIT;
    end else if (roll < 13) begin
      pick = $urandom_range(0, 3);
      case (pick)
        0: begin
          act = ACT_FREE;
          has = 1'b0;
        end
        1: act = ACT_IGNORED;
        2: begin
          act = ACT_FREE;
          has = 1'b1;
        end
        default: begin
          // Likely a slot that is already free.
          act = ACT_FREE;
          has = 1'b1;
          if (pool_q != 0) slot = LINK_W'($urandom_range(0, pool_q - 1));
        end
      endcase
    end else if (granted_slots_out.size() != 0 && roll < (pool_draining ? 30 : 80)) begin
      act = ACT_FREE;
      has = 1'b1;
      pick = $urandom_range(0, granted_slots_out.size() - 1);
      slot = granted_slots_out[pick];
      granted_slots_out.delete(pick);
    end else begin
      act = ACT_ALLOC;
    end
    issue_pool_request(act, has, slot);
  endtask

  // Compare each result item with the oldest prediction.
  always @(posedge clk_i) begin : check_pool_result
    res_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      status_seen[m_axis_tuser] = 1'b1;
      if (expected_pool_results.size() == 0) begin
        $error("result item with no prediction pending: status %0d slot %0d count %0d",
               m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[16:8]);
        err_count++;
      end else begin
        exp_r = expected_pool_results.pop_front();
        if (m_axis_tuser != exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, m_axis_tuser);
          err_count++;
        end
        if (m_axis_tdata[7:0] != exp_r.granted_slot) begin
          $error("granted_slot: expected %0d, actual %0d", exp_r.granted_slot,
                 m_axis_tdata[7:0]);
          err_count++;
        end
        if (m_axis_tdata[16:8] != exp_r.free_count) begin
          $error("free_count: expected %0d, actual %0d", exp_r.free_count,
                 m_axis_tdata[16:8]);
          err_count++;
        end
      end
    end
  end

  // Result side ready: short random stalls, or one long hold on request.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD_CYCLES;
      end else if (stall_left == 0 && sink_stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      m_axis_tready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Before any init the pool is empty and has no room for a returned slot.
  task automatic test_empty_pool();
    issue_pool_request(ACT_ALLOC, 1'b0, 8'd0);
    issue_pool_request(ACT_FREE, 1'b1, 8'd255);
    issue_pool_request(ACT_FREE, 1'b0, 8'd0);
    issue_pool_request(ACT_IGNORED, 1'b1, 8'hAA);
    issue_pool_request(ACT_ALLOC, 1'b1, 8'h55);
  endtask

  // Zero count is rejected; a single-slot pool empties, rejects a stray index and fills.
  task automatic test_zero_and_single();
    write_slot_count(9'd0);
    issue_pool_request(ACT_INIT, 1'b0, 8'd0);
    write_slot_count(9'd1);
    issue_pool_request(ACT_INIT, 1'b1, 8'd0);
    issue_pool_request(ACT_ALLOC, 1'b0, 8'd0);
    issue_pool_request(ACT_ALLOC, 1'b0, 8'd0);
    issue_pool_request(ACT_FREE, 1'b1, 8'd5);
    issue_pool_request(ACT_FREE, 1'b1, 8'd0);
    issue_pool_request(ACT_FREE, 1'b1, 8'd0);
  endtask

  // A count above the pool size links every slot; the top slot comes out first.
  task automatic test_clamped_count();
    write_slot_count(9'd511);
    issue_pool_request(ACT_INIT, 1'b0, 8'hFF);
    issue_pool_request(ACT_ALLOC, 1'b0, 8'd0);
    issue_pool_request(ACT_FREE, 1'b1, 8'd255);
    issue_pool_request(ACT_FREE, 1'b1, 8'd0);
  endtask

  // Index out of the linked range is rejected; a slot freed twice is pushed twice.
  task automatic test_duplicate_free();
    write_slot_count(9'd4);
    issue_pool_request(ACT_INIT, 1'b0, 8'd0);
    issue_pool_request(ACT_ALLOC, 1'b0, 8'd0);
    issue_pool_request(ACT_ALLOC, 1'b0, 8'd0);
    issue_pool_request(ACT_FREE, 1'b1, 8'd255);
    issue_pool_request(ACT_FREE, 1'b1, 8'd2);
    issue_pool_request(ACT_FREE, 1'b1, 8'd2);
    issue_pool_request(ACT_ALLOC, 1'b0, 8'd0);
    issue_pool_request(ACT_ALLOC, 1'b0, 8'd0);
  endtask

  // Random traffic over a range of pool sizes, the extremes among them.
  task automatic test_random_traffic();
    logic [CNT_W-1:0] counts [9];
    int p;
    int k;
    counts = '{9'd256, 9'd1, 9'd2, 9'd0, 9'd3, 9'd16, 9'd300, 9'd511, 9'd0};
    counts[8] = CNT_W'($urandom_range(4, 255));
    for (p = 0; p < 9; p++) begin
      write_slot_count(counts[p]);
      issue_pool_request(ACT_INIT, 1'($urandom_range(0, 1)), LINK_W'($urandom));
      for (k = 0; k < 95; k++) send_random_item();
    end
  endtask

  // The result side holds off while items keep coming, then the sender waits it out.
  task automatic test_backpressure();
    int k;
    write_slot_count(9'd32);
    issue_pool_request(ACT_INIT, 1'b0, 8'd0);
    src_gaps_on = 1'b0;
    long_hold_req = 1'b1;
    for (k = 0; k < 40; k++) send_random_item();
    drain_results();
    src_gaps_on = 1'b1;
    for (k = 0; k < 10; k++) send_random_item();
  endtask

  // Closing stretch with neither side idling.
  task automatic test_unthrottled_tail();
    int k;
    write_slot_count(9'd8);
    src_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    issue_pool_request(ACT_INIT, 1'b0, 8'd0);
    for (k = 0; k < 100; k++) send_random_item();
  endtask

  initial begin : run_tests
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_pool();
    test_zero_and_single();
    test_clamped_count();
    test_duplicate_free();
    test_random_traffic();
    test_backpressure();
    test_unthrottled_tail();
    drain_results();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d items and checked %0d results over %0d slot count settings.",
             items_sent, results_seen, settings_used);
    $display("Status codes returned (one bit per code, code 0 lowest): %b.", status_seen);
    if (err_count == 0 && expected_pool_results.size() == 0) begin
      $display("free_list_slot_allocator_core_tb passed");
    end else begin
      $display("free_list_slot_allocator_core_tb failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #2_000_000;
    $display("free_list_slot_allocator_core_tb failed");
    $finish;
  end

endmodule
